[hw/rtl/pool_2x2_stride2_stream_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 pooling core
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef POOL_2X2_STRIDE2_STREAM_CORE_ASSERT_SVH
`define POOL_2X2_STRIDE2_STREAM_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define PL2_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pool core assertion failed");

// Antecedent implies consequent on the following clock
`define PL2_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pool core assertion failed");

`endif

[hw/rtl/pl2_pkg.sv]
// ----------------------------------------------------------------------------
// pl2_pkg
// Shared types, register codes and the window combine function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pl2_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned PairW    = 9;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 11;

  // Register indices on the configuration port
  localparam logic [CfgAddrW-1:0] CfgFrameWidth   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgFrameHeight  = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgChannelCount = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgPoolMode     = 2'd3;

  typedef enum logic [1:0] {
    PoolMax = 2'd0,
    PoolMin = 2'd1,
    PoolAvg = 2'd2
  } pool_mode_e;

  // Max, min or sum of two values
  function automatic logic [PairW:0] combine(input logic [PairW-1:0] a,
                                             input logic [PairW-1:0] b,
                                             input pool_mode_e      mode);
    logic [PairW:0] res;
    case (mode)
      PoolMin: res = (a < b) ? {1'b0, a} : {1'b0, b};
      PoolAvg: res = {1'b0, a} + {1'b0, b};
      default: res = (a > b) ? {1'b0, a} : {1'b0, b};
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/pl2_ram.sv]
// ----------------------------------------------------------------------------
// pl2_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pl2_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pool_2x2_stride2_stream_core.sv]
// Result path: odd-row, odd-column samples pass stage 1, then the output register.
// Throughput: one sample per cycle unless stalled; each sample makes at most one line
//   store access (even rows write, odd rows read), so the single RAM keeps pace.
// Reset: position counters clear, registers return to 640x480, 3 channels, maximum.
//   The line store and the per-channel pair holds are not cleared.
// ----------------------------------------------------------------------------
// pool_2x2_stride2_stream_core
// 2x2 stride-2 max/min/average pooling over a channel-interleaved sample stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pool_2x2_stride2_stream_core_assert.svh"

module pool_2x2_stride2_stream_core #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Sample stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] sample
  // Pooled stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // [7:0] pooled_value
  output logic                            m_axis_tlast_o,  // frame_last
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [pl2_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [pl2_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int unsigned ColW   = $clog2(MAX_WIDTH);
  localparam int unsigned RowW   = $clog2(MAX_HEIGHT);
  localparam int unsigned ChW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned WdW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HtW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NchW   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned Depth  = (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RstWd  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int unsigned RstHt  = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
  localparam int unsigned RstNch = (3 > MAX_CHANNELS) ? MAX_CHANNELS : 3;

  // Configuration, held already clamped
  logic [WdW-1:0]      width_q, width_d;
  logic [HtW-1:0]      height_q, height_d;
  logic [NchW-1:0]     nch_q, nch_d;
  pl2_pkg::pool_mode_e mode_q, mode_d;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    nch_d    = nch_q;
    mode_d   = mode_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        pl2_pkg::CfgFrameWidth: begin
          if (cfg_wdata_i < 11'd2)                 width_d = WdW'(2);
          else if (32'(cfg_wdata_i) > MAX_WIDTH)   width_d = WdW'(MAX_WIDTH);
          else                                     width_d = WdW'(cfg_wdata_i);
        end
        pl2_pkg::CfgFrameHeight: begin
          if (cfg_wdata_i < 11'd2)                 height_d = HtW'(2);
          else if (32'(cfg_wdata_i) > MAX_HEIGHT)  height_d = HtW'(MAX_HEIGHT);
          else                                     height_d = HtW'(cfg_wdata_i);
        end
        pl2_pkg::CfgChannelCount: begin
          if (cfg_wdata_i[2:0] == 3'd0)                  nch_d = NchW'(1);
          else if (32'(cfg_wdata_i[2:0]) > MAX_CHANNELS) nch_d = NchW'(MAX_CHANNELS);
          else                                           nch_d = NchW'(cfg_wdata_i[2:0]);
        end
        pl2_pkg::CfgPoolMode: begin
          case (cfg_wdata_i[1:0])
            pl2_pkg::PoolMin: mode_d = pl2_pkg::PoolMin;
            pl2_pkg::PoolAvg: mode_d = pl2_pkg::PoolAvg;
            default:          mode_d = pl2_pkg::PoolMax;  // unused code acts as maximum
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WdW'(RstWd);
      height_q <= HtW'(RstHt);
      nch_q    <= NchW'(RstNch);
      mode_q   <= pl2_pkg::PoolMax;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      nch_q    <= nch_d;
      mode_q   <= mode_d;
    end
  end

  // Handshake and pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_go, in_ready, accept;

  assign s1_go    = !out_valid_q || m_axis_tready_i;
  assign in_ready = !s1_valid_q || s1_go;
  assign accept   = s_axis_tvalid_i && in_ready;

  // Position counters
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic            ch_wrap, col_wrap, row_wrap;
  logic            col_odd, row_odd, at_last;

  assign ch_wrap  = (32'(ch_q) + 32'd1) >= 32'(nch_q);
  assign col_wrap = (32'(col_q) + 32'd1) >= 32'(width_q);
  assign row_wrap = (32'(row_q) + 32'd1) >= 32'(height_q);
  assign col_odd  = col_q[0];
  assign row_odd  = row_q[0];
  assign at_last  = ch_wrap &&
                    (32'(col_q) == ((32'(width_q) & ~32'd1) - 32'd1)) &&
                    (32'(row_q) == ((32'(height_q) & ~32'd1) - 32'd1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ch_d  = ch_q;
    if (accept) begin
      if (ch_wrap) begin
        ch_d = '0;
        if (col_wrap) begin
          col_d = '0;
          row_d = row_wrap ? '0 : row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end else begin
        ch_d = ch_q + ChW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ch_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ch_q  <= ch_d;
    end
  end

  // Even-column sample per channel
  logic [7:0] hold_q [MAX_CHANNELS];

  always_ff @(posedge clk_i) begin
    if (accept && !col_odd) begin
      hold_q[ch_q] <= s_axis_tdata_i;
    end
  end

  // Horizontal pair and line store access
  logic [pl2_pkg::PairW:0]   pair_full;
  logic [pl2_pkg::PairW-1:0] pair;
  logic [AddrW-1:0]          ram_addr;
  logic                      ram_we, ram_re;
  logic [pl2_pkg::PairW-1:0] ram_rdata;

  assign pair_full = pl2_pkg::combine({1'b0, hold_q[ch_q]}, {1'b0, s_axis_tdata_i}, mode_q);
  assign pair      = pair_full[pl2_pkg::PairW-1:0];
  assign ram_addr  = AddrW'((32'(col_q) >> 1) * MAX_CHANNELS + 32'(ch_q));
  assign ram_we    = accept && col_odd && !row_odd;
  assign ram_re    = accept && col_odd && row_odd;

  // Write and read never share a cycle: row parity separates them,
  // and a write always lands before a read of the same entry.
  pl2_ram #(
    .WIDTH (pl2_pkg::PairW),
    .DEPTH (Depth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (pair),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Stage 1: pair waiting for the stored row above
  logic [pl2_pkg::PairW-1:0] s1_pair_q;
  logic                      s1_last_q;

  assign s1_valid_d = (s1_valid_q && !s1_go) ? 1'b1 : ram_re;

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_pair_q <= pair;
      s1_last_q <= at_last;
    end
  end

  // Vertical combine and output register
  logic [pl2_pkg::PairW:0] win;
  logic [7:0]              out_data_q;
  logic                    out_last_q;

  assign win = pl2_pkg::combine(ram_rdata, s1_pair_q, mode_q);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_go) begin
      out_data_q <= (mode_q == pl2_pkg::PoolAvg) ? win[9:2] : win[7:0];
      out_last_q <= s1_last_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_go)  out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  `PL2_ASSERT_ALWAYS(a_ram_rw_exclusive, !(ram_we && ram_re))
  `PL2_ASSERT_ALWAYS(a_no_read_when_stalled, !(s1_valid_q && !s1_go && ram_re))
  `PL2_ASSERT_NEXT(a_read_fills_stage1, ram_re, s1_valid_q)
  `PL2_ASSERT_NEXT(a_stage1_drains_to_out, s1_valid_q && s1_go, out_valid_q)

endmodule
